// File: hw/rtl/nearest_centroid_wcss_core_macros.svh
// Assertion macros shared by the checker of the nearest-centroid WCSS core.
`ifndef NEAREST_CENTROID_WCSS_CORE_MACROS_SVH
`define NEAREST_CENTROID_WCSS_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define NCW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define NCW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ncw_pkg.sv
// Types, constants and codes shared by the nearest-centroid WCSS core.
`timescale 1ns / 1ps
package ncw_pkg;

    // Fixed field widths.
    localparam int COORD_BITS = 16;
    localparam int CI_W       = 4;
    localparam int DI_W       = 4;
    localparam int CNT_W      = 5;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int PSUM_W     = 37;
    localparam int DIST_W     = 36;
    localparam int WCSS_W     = 48;

    // Sizes.
    localparam int PSUM_SLOTS        = 16;
    localparam int NCW_MAX_CENTROIDS = 16;
    localparam int NCW_MAX_DIMS      = 16;
    localparam int FIFO_DEPTH        = 2;

    // Configuration register indexes.
    localparam logic CFG_ACTIVE_CENTROIDS = 1'b0;
    localparam logic CFG_ACTIVE_DIMS      = 1'b1;

    // Command codes of an input word.
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_POINT = 2'd1,
        CMD_CLEAR = 2'd2
    } t_ncw_cmd;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        BS_IDLE,
        BS_ISSUE,
        BS_DRAIN,
        BS_MIN,
        BS_POST
    } t_ncw_bstate;

    // One classified command word between front and back.
    typedef struct packed {
        t_ncw_cmd                op;
        logic [CI_W-1:0]         ci;
        logic [DI_W-1:0]         di;
        logic [COORD_BITS-1:0]   val;
        logic                    fin;
        logic                    last;
    } t_ncw_item;

    // One result word.
    typedef struct packed {
        logic [DIST_W-1:0] min_dist;
        logic [WCSS_W-1:0] wcss;
        logic              done;
        logic              sat;
    } t_ncw_res;

endpackage

// File: hw/rtl/nearest_centroid_wcss_core.sv
// Top level of the nearest-centroid WCSS core.
`timescale 1ns / 1ps
// Streams point coordinates against a loaded centroid set and reports, for each
// completed point, the squared distance to its nearest centroid and the running
// within-cluster sum of squares, which saturates at its maximum. Input and output
// both behave as queues: a word is taken when push is high and full is low, and a
// result is taken when pop is high and empty is low. A front end classifies words
// and drops those with no effect (unused command, coordinate beyond the active
// dimensions, load outside the store); a two-word queue feeds the back end, which
// owns the centroid store and one shared subtract-square-accumulate unit. A centroid
// load or a clear is handled in the idle state. A point coordinate makes one store read
// per active centroid through the shared unit's four-stage pipeline (store read,
// absolute difference, square, accumulate). The coordinate that completes a point adds
// a minimum search over the partial sums and a WCSS update. Configuration must be
// written only while idle; the block itself does not enforce this.
module nearest_centroid_wcss_core import ncw_pkg::*; #(
    parameter int MAX_CENTROIDS = NCW_MAX_CENTROIDS,
    parameter int MAX_DIMS      = NCW_MAX_DIMS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CNT_W-1:0]      i_cfg_wdata,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_command,
    input  logic [CI_W-1:0]       i_centroid_index,
    input  logic [DI_W-1:0]       i_coord_index,
    input  logic signed [COORD_BITS-1:0] i_coord_value,
    input  logic                  i_last_point,
    output logic                  empty,
    input  logic                  pop,
    output logic [DIST_W-1:0]     o_point_min_sq_dist,
    output logic [WCSS_W-1:0]     o_wcss_total,
    output logic                  o_set_done,
    output logic                  o_saturated
);

    logic             q_push;
    logic             q_pop;
    logic             q_empty;
    t_ncw_item        q_in;
    t_ncw_item        q_out;
    logic [CNT_W-1:0] nc;
    logic             res_push;
    logic             res_full;
    t_ncw_res         res_in;
    t_ncw_res         res_out;

    // Front end: accepts and classifies input words.
    ncw_front #(
        .MAX_CENTROIDS(MAX_CENTROIDS),
        .MAX_DIMS     (MAX_DIMS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_push          (push),
        .i_command       (i_command),
        .i_centroid_index(i_centroid_index),
        .i_coord_index   (i_coord_index),
        .i_coord_value   (i_coord_value),
        .i_last_point    (i_last_point),
        .i_q_full        (full),
        .o_q_push        (q_push),
        .o_q_item        (q_in),
        .o_nc            (nc)
    );

    // Command queue between front and back.
    ncw_fifo #(
        .W($bits(t_ncw_item))
    ) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .o_full (full),
        .i_pop  (q_pop),
        .o_data (q_out),
        .o_empty(q_empty)
    );

    // Back end: store, accumulate, minimum and WCSS.
    ncw_back #(
        .MAX_CENTROIDS(MAX_CENTROIDS),
        .MAX_DIMS     (MAX_DIMS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_nc      (nc),
        .i_q_empty (q_empty),
        .i_q_item  (q_out),
        .o_q_pop   (q_pop),
        .i_res_full(res_full),
        .o_res_push(res_push),
        .o_res     (res_in)
    );

    // Result queue toward the consumer.
    ncw_fifo #(
        .W($bits(t_ncw_res))
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_in),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (res_out),
        .o_empty(empty)
    );

    assign o_point_min_sq_dist = res_out.min_dist;
    assign o_wcss_total        = res_out.wcss;
    assign o_set_done          = res_out.done;
    assign o_saturated         = res_out.sat;

endmodule

// File: hw/rtl/ncw_fifo.sv
// Small first-in first-out queue used between the core's stages and at its output.
`timescale 1ns / 1ps
module ncw_fifo import ncw_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    logic [W-1:0] r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == (PW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: hw/rtl/ncw_front.sv
// Front end: configuration registers, input acceptance and command classification.
`timescale 1ns / 1ps
module ncw_front import ncw_pkg::*; #(
    parameter int MAX_CENTROIDS = NCW_MAX_CENTROIDS,
    parameter int MAX_DIMS      = NCW_MAX_DIMS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CNT_W-1:0]      i_cfg_wdata,
    input  logic                  i_push,
    input  logic [1:0]            i_command,
    input  logic [CI_W-1:0]       i_centroid_index,
    input  logic [DI_W-1:0]       i_coord_index,
    input  logic [COORD_BITS-1:0] i_coord_value,
    input  logic                  i_last_point,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_ncw_item             o_q_item,
    output logic [CNT_W-1:0]      o_nc
);

    localparam int NC_CAP = (MAX_CENTROIDS < PSUM_SLOTS) ? MAX_CENTROIDS : PSUM_SLOTS;

    logic [CNT_W-1:0] r_active_centroids;
    logic [CNT_W-1:0] r_active_dims;
    logic [8:0]       nd;
    logic             keep;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_centroids <= CNT_W'(16);
            r_active_dims      <= CNT_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_CENTROIDS: r_active_centroids <= i_cfg_wdata;
                CFG_ACTIVE_DIMS:      r_active_dims      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective counts: zero acts as one, large values clamp to the maximum.
    always_comb begin
        if (r_active_centroids == '0) begin
            o_nc = CNT_W'(1);
        end else if (9'(r_active_centroids) > 9'(NC_CAP)) begin
            o_nc = CNT_W'(NC_CAP);
        end else begin
            o_nc = r_active_centroids;
        end
        if (r_active_dims == '0) begin
            nd = 9'd1;
        end else if (9'(r_active_dims) > 9'(MAX_DIMS)) begin
            nd = 9'(MAX_DIMS);
        end else begin
            nd = 9'(r_active_dims);
        end
    end

    // Drop words that have no effect; pass the rest on to the back end.
    always_comb begin
        unique case (i_command)
            CMD_LOAD:  keep = (9'(i_centroid_index) < 9'(MAX_CENTROIDS)) &&
                              (9'(i_coord_index) < 9'(MAX_DIMS));
            CMD_POINT: keep = (9'(i_coord_index) < nd);
            CMD_CLEAR: keep = 1'b1;
            default:   keep = 1'b0;
        endcase
    end

    assign o_q_push      = i_push && !i_q_full && keep;
    assign o_q_item.op   = t_ncw_cmd'(i_command);
    assign o_q_item.ci   = i_centroid_index;
    assign o_q_item.di   = i_coord_index;
    assign o_q_item.val  = i_coord_value;
    assign o_q_item.fin  = (9'(i_coord_index) == nd - 9'd1);
    assign o_q_item.last = i_last_point;

endmodule

// File: hw/rtl/ncw_back.sv
// Back end: centroid store, shared subtract-square-accumulate unit, minimum search and WCSS.
`timescale 1ns / 1ps
module ncw_back import ncw_pkg::*; #(
    parameter int MAX_CENTROIDS = NCW_MAX_CENTROIDS,
    parameter int MAX_DIMS      = NCW_MAX_DIMS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_nc,
    input  logic             i_q_empty,
    input  t_ncw_item        i_q_item,
    output logic             o_q_pop,
    input  logic             i_res_full,
    output logic             o_res_push,
    output t_ncw_res         o_res
);

    localparam int DEPTH = MAX_CENTROIDS * MAX_DIMS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(PSUM_SLOTS);

    logic [COORD_BITS-1:0] r_store [DEPTH];

    t_ncw_bstate           r_state;
    t_ncw_bstate           n_state;
    t_ncw_item             r_item;
    logic [SW-1:0]         r_c;
    logic [SW-1:0]         r_m;
    logic [COORD_BITS-1:0] r_rdata;
    logic                  r_s1_vld;
    logic [SW-1:0]         r_s1_c;
    logic                  r_s2_vld;
    logic [SW-1:0]         r_s2_c;
    logic [COORD_BITS-1:0] r_s2_mag;
    logic                  r_s3_vld;
    logic [SW-1:0]         r_s3_c;
    logic [SQ_W-1:0]       r_s3_sq;
    logic [PSUM_W-1:0]     r_psum [PSUM_SLOTS];
    logic [PSUM_SLOTS-1:0] r_psum_vld;
    logic [PSUM_W-1:0]     r_best;
    logic [WCSS_W-1:0]     r_wcss;
    logic                  r_sat;

    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic                  last_c;
    logic                  last_m;
    logic                  pipe_busy;
    logic signed [COORD_BITS:0] diff;
    logic [COORD_BITS-1:0] mag;
    logic [SW-1:0]         psum_ra;
    logic [PSUM_W-1:0]     psum_rd;
    logic [PSUM_W:0]       acc_sum;
    logic [PSUM_W-1:0]     acc_val;
    logic [DIST_W-1:0]     best_d;
    logic [WCSS_W:0]       wsum;
    logic                  wsat;
    logic [WCSS_W-1:0]     wnew;
    logic                  take_clear;
    logic                  take_load;

    // Store addresses: centroid-major, one row of MAX_DIMS per centroid.
    assign wr_addr = AW'(int'(i_q_item.ci) * MAX_DIMS + int'(i_q_item.di));
    assign rd_addr = AW'(int'(r_c) * MAX_DIMS + int'(r_item.di));

    assign last_c    = ({1'b0, r_c} == i_nc - CNT_W'(1));
    assign last_m    = ({1'b0, r_m} == i_nc - CNT_W'(1));
    assign pipe_busy = r_s1_vld || r_s2_vld || r_s3_vld;

    // Absolute coordinate difference.
    assign diff = $signed({r_item.val[COORD_BITS-1], r_item.val}) -
                  $signed({r_rdata[COORD_BITS-1], r_rdata});
    assign mag  = diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];

    // One read port on the partial sums, shared by accumulate and minimum search.
    assign psum_ra = (r_state == BS_MIN) ? r_m : r_s3_c;
    assign psum_rd = r_psum_vld[psum_ra] ? r_psum[psum_ra] : '0;

    // Saturating partial-sum accumulate.
    assign acc_sum = {1'b0, psum_rd} + (PSUM_W+1)'(r_s3_sq);
    assign acc_val = acc_sum[PSUM_W] ? '1 : acc_sum[PSUM_W-1:0];

    // Nearest distance clamp and saturating WCSS update.
    assign best_d = r_best[PSUM_W-1] ? '1 : r_best[DIST_W-1:0];
    assign wsum   = {1'b0, r_wcss} + (WCSS_W+1)'(best_d);
    assign wsat   = wsum[WCSS_W] || (r_wcss == '1);
    assign wnew   = wsat ? '1 : wsum[WCSS_W-1:0];

    assign o_res.min_dist = best_d;
    assign o_res.wcss     = wnew;
    assign o_res.done     = r_item.last;
    assign o_res.sat      = r_sat || wsat;

    assign take_clear = o_q_pop && (i_q_item.op == CMD_CLEAR);
    assign take_load  = o_q_pop && (i_q_item.op == CMD_LOAD);

    // Sequencer: next state and handshakes.
    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        o_res_push = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.op == CMD_POINT) begin
                        n_state = BS_ISSUE;
                    end
                end
            end
            BS_ISSUE: begin
                if (last_c) begin
                    n_state = BS_DRAIN;
                end
            end
            BS_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = r_item.fin ? BS_MIN : BS_IDLE;
                end
            end
            BS_MIN: begin
                if (last_m) begin
                    n_state = BS_POST;
                end
            end
            BS_POST: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_IDLE;
            r_c        <= '0;
            r_m        <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_s3_vld   <= 1'b0;
            r_psum_vld <= '0;
            r_wcss     <= '0;
            r_sat      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s1_vld <= (r_state == BS_ISSUE);
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            if (r_state == BS_IDLE) begin
                r_c <= '0;
            end else if (r_state == BS_ISSUE) begin
                r_c <= r_c + 1'b1;
            end
            if (r_state == BS_DRAIN) begin
                r_m <= '0;
            end else if (r_state == BS_MIN) begin
                r_m <= r_m + 1'b1;
            end
            if (take_clear || o_res_push) begin
                r_psum_vld <= '0;
            end else if (r_s3_vld) begin
                r_psum_vld[r_s3_c] <= 1'b1;
            end
            if (take_clear) begin
                r_wcss <= '0;
                r_sat  <= 1'b0;
            end else if (o_res_push) begin
                r_wcss <= wnew;
                r_sat  <= r_sat || wsat;
            end
        end
    end

    // Datapath registers and the centroid store.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
        end
        if (take_load) begin
            r_store[wr_addr] <= i_q_item.val;
        end
        r_rdata  <= r_store[rd_addr];
        r_s1_c   <= r_c;
        r_s2_c   <= r_s1_c;
        r_s2_mag <= mag;
        r_s3_c   <= r_s2_c;
        r_s3_sq  <= r_s2_mag * r_s2_mag;
        if (r_s3_vld) begin
            r_psum[r_s3_c] <= acc_val;
        end
        if (r_state == BS_DRAIN) begin
            r_best <= '1;
        end else if ((r_state == BS_MIN) && (psum_rd < r_best)) begin
            r_best <= psum_rd;
        end
    end

endmodule

// File: hw/rtl/ncw_checker.sv
// Port-level assertions for the nearest-centroid WCSS core, bound to its top level.
`timescale 1ns / 1ps
`include "nearest_centroid_wcss_core_macros.svh"
module ncw_checker import ncw_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input logic [DIST_W-1:0]     o_point_min_sq_dist,
    input logic [WCSS_W-1:0]     o_wcss_total,
    input logic                  o_saturated
);

    // Both queues come out of reset with nothing in them.
    `NCW_ASSERT_IMP(a_reset_clean, $past(!i_rst_n), empty && !full, "queues not clear after reset")

    // A saturated result always reports the total pinned at its maximum.
    `NCW_ASSERT_IMP(a_sat_pinned, !empty && o_saturated, o_wcss_total == '1,
        "saturated flag without a full-scale total")

    // The running total never falls below the distance just added to it.
    `NCW_ASSERT_IMP(a_total_covers, !empty, {12'b0, o_point_min_sq_dist} <= o_wcss_total,
        "total below the point distance")

    // A result that is not taken stays on the ports.
    `NCW_ASSERT_NXT(a_res_hold, !empty && !pop,
        !empty && $stable(o_wcss_total) && $stable(o_point_min_sq_dist),
        "pending result changed")

endmodule

bind nearest_centroid_wcss_core ncw_checker u_ncw_checker (.*);
